// ===== rtl/c8ic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CHIP-8 instruction core package
// Sizes, action codes and sequencer state type shared by the core.
// ----------------------------------------------------------------------------
package c8ic_pkg;

   localparam int MEM_BYTES     = 4096;
   localparam int STACK_DEPTH   = 16;
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int ADDR_W        = 12;
   localparam logic [ADDR_W-1:0] START_RESET = 12'd512;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_STEP = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_FHI   = 11'b00000000010,
      ST_FLO   = 11'b00000000100,
      ST_DEC   = 11'b00000001000,
      ST_EXEC  = 11'b00000010000,
      ST_RET   = 11'b00000100000,
      ST_CLR   = 11'b00001000000,
      ST_DMEM  = 11'b00010000000,
      ST_DROW  = 11'b00100000000,
      ST_DWR   = 11'b01000000000,
      ST_DONE  = 11'b10000000000
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/chip8_instruction_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CHIP-8 instruction core
// One action per transfer: load a byte, step one instruction, read a row.
// Load and read go straight to done; a step runs fetch, decode and execute;
// CLS and RET add a state; a draw adds memory, row and write states per row.
// One item at a time; the result register frees the input once it is taken.
// Reset clears registers and display row valid bits and sets the PC to START_RESET.
// ----------------------------------------------------------------------------
module chip8_instruction_core #(
   parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [11:0]  csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // action[1:0], mem_address[13:2], mem_data[21:14], row_select[26:22]
   input  wire logic [31:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pc_value[11:0], opcode_seen[27:12], screen_changed[28], unsupported[29],
   // row_pixels[93:30]
   output logic [95:0]       rsp_tdata
);

   localparam int SPW = $clog2(STACK_DEPTH);

   c8ic_pkg::state_type st_ff, st_in;

   logic [7:0]  mem [c8ic_pkg::MEM_BYTES];
   logic [63:0] disp [c8ic_pkg::SCREEN_HEIGHT];
   logic [11:0] stk [STACK_DEPTH];
   logic [7:0]  v_ff [16];
   logic [31:0] rv_ff;

   logic [11:0] pc_ff, start_ff, i_ff;
   logic [SPW-1:0] sp_ff;
   logic [SPW-1:0] sp_dec, sp_inc;
   logic [7:0]  dt_ff, st8_ff;
   logic [15:0] op_ff;
   logic [31:0] req_ff;
   logic        chg_ff, uns_ff, hit_ff;
   logic [7:0]  mrd_ff;
   logic [11:0] maddr;
   logic [63:0] drd_ff;
   logic [4:0]  dra;
   logic [4:0]  row_ff;
   logic [3:0]  cnt_ff;
   logic [95:0] out_ff;
   logic        ov_ff;
   logic [11:0] srd_ff;

   logic [3:0]  x, y, n;
   logic [7:0]  kk, vx, vy;
   logic [63:0] bits, rowv;
   logic [8:0]  sum;

   assign x  = op_ff[11:8];
   assign y  = op_ff[7:4];
   assign n  = op_ff[3:0];
   assign kk = op_ff[7:0];
   assign vx = v_ff[x];
   assign vy = v_ff[y];
   assign sum = {1'b0, vx} + {1'b0, vy};
   assign bits = {mrd_ff, 56'd0} >> v_ff[x][5:0];
   assign rowv = rv_ff[row_ff] ? drd_ff : 64'd0;

   assign sp_dec = (sp_ff == '0) ? SPW'(STACK_DEPTH - 1) : sp_ff - SPW'(1);
   assign sp_inc = (sp_ff == SPW'(STACK_DEPTH - 1)) ? '0 : sp_ff + SPW'(1);

   assign req_tready = (st_ff == c8ic_pkg::ST_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      unique case (st_ff)
         c8ic_pkg::ST_FHI:  maddr = pc_ff;
         c8ic_pkg::ST_FLO:  maddr = pc_ff + 12'd1;
         default:           maddr = i_ff + {8'd0, cnt_ff};
      endcase
      if (st_ff == c8ic_pkg::ST_IDLE) dra = req_tdata[26:22];
      else dra = row_ff;
   end

   always_ff @(posedge clock) begin
      mrd_ff <= mem[maddr];
      drd_ff <= disp[dra];
      srd_ff <= stk[sp_dec];
      if (st_ff == c8ic_pkg::ST_IDLE && req_tvalid && req_tready &&
          req_tdata[1:0] == c8ic_pkg::ACT_LOAD)
         mem[req_tdata[13:2]] <= req_tdata[21:14];
      if (st_ff == c8ic_pkg::ST_DWR) disp[row_ff] <= rowv ^ bits;
      if (st_ff == c8ic_pkg::ST_EXEC && op_ff[15:12] == 4'h2) stk[sp_ff] <= pc_ff;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         c8ic_pkg::ST_IDLE:
            if (req_tvalid && req_tready) begin
               if (req_tdata[1:0] == c8ic_pkg::ACT_STEP) st_in = c8ic_pkg::ST_FHI;
               else st_in = c8ic_pkg::ST_DONE;
            end
         c8ic_pkg::ST_FHI:  st_in = c8ic_pkg::ST_FLO;
         c8ic_pkg::ST_FLO:  st_in = c8ic_pkg::ST_DEC;
         c8ic_pkg::ST_DEC:  st_in = c8ic_pkg::ST_EXEC;
         c8ic_pkg::ST_EXEC:
            if (op_ff == 16'h00E0) st_in = c8ic_pkg::ST_CLR;
            else if (op_ff == 16'h00EE) st_in = c8ic_pkg::ST_RET;
            else if (op_ff[15:12] == 4'hD) begin
               if (n == 4'd0) st_in = c8ic_pkg::ST_DONE;
               else st_in = c8ic_pkg::ST_DMEM;
            end else st_in = c8ic_pkg::ST_DONE;
         c8ic_pkg::ST_RET:  st_in = c8ic_pkg::ST_DONE;
         c8ic_pkg::ST_CLR:  st_in = c8ic_pkg::ST_DONE;
         c8ic_pkg::ST_DMEM: st_in = c8ic_pkg::ST_DROW;
         c8ic_pkg::ST_DROW: st_in = c8ic_pkg::ST_DWR;
         c8ic_pkg::ST_DWR:
            if (cnt_ff == n - 4'd1 || row_ff == 5'd31) st_in = c8ic_pkg::ST_DONE;
            else st_in = c8ic_pkg::ST_DMEM;
         c8ic_pkg::ST_DONE: st_in = c8ic_pkg::ST_IDLE;
         default:           st_in = c8ic_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= c8ic_pkg::ST_IDLE;
         ov_ff    <= 1'b0;
         rv_ff    <= '0;
         start_ff <= c8ic_pkg::START_RESET;
         pc_ff    <= c8ic_pkg::START_RESET;
         i_ff     <= '0;
         sp_ff    <= '0;
         dt_ff    <= '0;
         st8_ff   <= '0;
         for (int k = 0; k < 16; k++) v_ff[k] <= '0;
      end else begin
         st_ff <= st_in;
         if (ov_ff && rsp_tready) ov_ff <= 1'b0;
         if (csr_we) begin
            start_ff <= csr_wdata;
            pc_ff    <= csr_wdata;
         end
         unique case (st_ff)
            c8ic_pkg::ST_IDLE:
               if (req_tvalid && req_tready) begin
                  req_ff <= req_tdata;
                  op_ff  <= '0;
                  chg_ff <= 1'b0;
                  uns_ff <= 1'b0;
                  hit_ff <= 1'b0;
                  cnt_ff <= '0;
               end
            c8ic_pkg::ST_FHI: ;
            c8ic_pkg::ST_FLO: op_ff[15:8] <= mrd_ff;
            c8ic_pkg::ST_DEC: begin
               op_ff[7:0] <= mrd_ff;
               pc_ff      <= pc_ff + 12'd2;
            end
            c8ic_pkg::ST_EXEC: begin
               row_ff <= v_ff[op_ff[7:4]][4:0];
               unique case (op_ff[15:12])
                  4'h0: if (op_ff != 16'h00E0 && op_ff != 16'h00EE) uns_ff <= 1'b1;
                        else if (op_ff == 16'h00EE) sp_ff <= sp_dec;
                  4'h1: pc_ff <= op_ff[11:0];
                  4'h2: begin
                     sp_ff <= sp_inc;
                     pc_ff <= op_ff[11:0];
                  end
                  4'h3: if (vx == kk) pc_ff <= pc_ff + 12'd2;
                  4'h4: if (vx != kk) pc_ff <= pc_ff + 12'd2;
                  4'h5: if (vx == vy) pc_ff <= pc_ff + 12'd2;
                  4'h6: v_ff[x] <= kk;
                  4'h7: v_ff[x] <= vx + kk;
                  4'h8: begin
                     unique case (n)
                        4'h0: v_ff[x] <= vy;
                        4'h1: v_ff[x] <= vx | vy;
                        4'h2: v_ff[x] <= vx & vy;
                        4'h3: v_ff[x] <= vx ^ vy;
                        4'h4: begin
                           v_ff[x] <= sum[7:0]; v_ff[15] <= {7'd0, sum[8]};
                        end
                        4'h5: begin
                           v_ff[x] <= vx - vy; v_ff[15] <= {7'd0, vx >= vy};
                        end
                        4'h6: begin
                           v_ff[x] <= vx >> 1; v_ff[15] <= {7'd0, vx[0]};
                        end
                        4'h7: begin
                           v_ff[x] <= vy - vx; v_ff[15] <= {7'd0, vy >= vx};
                        end
                        4'hE: begin
                           v_ff[x] <= vx << 1; v_ff[15] <= {7'd0, vx[7]};
                        end
                        default: uns_ff <= 1'b1;
                     endcase
                  end
                  4'h9: if (vx != vy) pc_ff <= pc_ff + 12'd2;
                  4'hA: i_ff <= op_ff[11:0];
                  4'hB: pc_ff <= op_ff[11:0] + {4'd0, v_ff[0]};
                  4'hD: begin
                     chg_ff <= 1'b1;
                     if (n == 4'd0) v_ff[15] <= 8'd0;
                  end
                  4'hF: begin
                     if (kk == 8'h07) v_ff[x] <= dt_ff;
                     else if (kk == 8'h15) dt_ff <= vx;
                     else if (kk == 8'h18) st8_ff <= vx;
                     else if (kk == 8'h1E) i_ff <= i_ff + {4'd0, vx};
                     else uns_ff <= 1'b1;
                  end
                  default: uns_ff <= 1'b1;
               endcase
            end
            c8ic_pkg::ST_RET: pc_ff <= srd_ff;
            c8ic_pkg::ST_CLR: begin
               rv_ff  <= '0;
               chg_ff <= 1'b1;
            end
            c8ic_pkg::ST_DMEM: ;
            c8ic_pkg::ST_DROW: ;
            c8ic_pkg::ST_DWR: begin
               rv_ff[row_ff] <= 1'b1;
               if ((rowv & bits) != 64'd0) hit_ff <= 1'b1;
               row_ff <= row_ff + 5'd1;
               cnt_ff <= cnt_ff + 4'd1;
               if (st_in == c8ic_pkg::ST_DONE)
                  v_ff[15] <= {7'd0, hit_ff || ((rowv & bits) != 64'd0)};
            end
            c8ic_pkg::ST_DONE: begin
               ov_ff  <= 1'b1;
               out_ff <= {2'b00,
                  (req_ff[1:0] == c8ic_pkg::ACT_READ)
                     ? (rv_ff[req_ff[26:22]] ? drd_ff : 64'd0) : 64'd0,
                  uns_ff, chg_ff, op_ff, pc_ff};
            end
            default: ;
         endcase
      end
   end

   logic unused_ok;
   assign unused_ok = ^{start_ff, st8_ff};

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 instruction core testbench
// Drives load, step, read and unused actions over the request stream. The
// programs are built so that no unwritten memory byte or stack entry is read.
// Every transfer is predicted by a behavioural copy of the interpreter state.
// Each response is checked field by field against the oldest prediction,
// with random stalls on both streams and start address changes between phases.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;
   localparam logic [3:0] GRP_SYS = 4'h0, GRP_JP = 4'h1, GRP_CALL = 4'h2, GRP_SE = 4'h3,
                          GRP_SNE = 4'h4, GRP_SER = 4'h5, GRP_LD = 4'h6, GRP_ADD = 4'h7,
                          GRP_ALU = 4'h8, GRP_SNER = 4'h9, GRP_LDI = 4'hA, GRP_JPV = 4'hB,
                          GRP_RND = 4'hC, GRP_DRW = 4'hD, GRP_KEY = 4'hE, GRP_MISC = 4'hF;
   localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3,
                          ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7,
                          ALU_SHL = 4'hE, ALU_BAD = 4'h8;
   localparam logic [7:0] FX_GETDT = 8'h07, FX_SETDT = 8'h15, FX_SETST = 8'h18,
                          FX_ADDI = 8'h1E, FX_BCD = 8'h33;
   localparam logic [3:0] VF = 4'hF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 80;

   typedef struct packed {
      logic [11:0] pc;
      logic [15:0] opcode;
      logic        changed;
      logic        unsup;
      logic [63:0] pixels;
   } core_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [11:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;

   // interpreter state
   logic [7:0]  mem [c8ic_pkg::MEM_BYTES];
   logic        mem_ok [c8ic_pkg::MEM_BYTES];
   logic [63:0] disp [c8ic_pkg::SCREEN_HEIGHT];
   logic [7:0]  vreg [16];
   logic [11:0] stk [c8ic_pkg::STACK_DEPTH];
   logic        stk_ok [c8ic_pkg::STACK_DEPTH];
   logic [11:0] pc, ireg;
   logic [3:0]  sp;
   logic [7:0]  dtimer, stimer;

   core_result_t pending_results[$];
   int error_count = 0;
   int items_sent = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int idle_cycles = 0;

   chip8_instruction_core u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void execute_step(ref core_result_t r);
      logic [15:0] op;
      logic [3:0]  x, y, n;
      logic [7:0]  kk, a, b;
      logic [8:0]  sum;
      logic [11:0] addr;
      logic [63:0] bits;
      logic        hit;
      int          row, col;
      op = {mem[pc], mem[pc + 12'd1]};
      r.opcode = op;
      pc = pc + 12'd2;
      x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
      a = vreg[x]; b = vreg[y];
      case (op[15:12])
         GRP_SYS: begin
            if (op == OP_CLS) begin
               for (int i = 0; i < c8ic_pkg::SCREEN_HEIGHT; i++) disp[i] = '0;
               r.changed = 1'b1;
            end else if (op == OP_RET) begin
               sp = sp - 4'd1;
               pc = stk[sp];
            end else r.unsup = 1'b1;
         end
         GRP_JP: pc = op[11:0];
         GRP_CALL: begin
            stk[sp] = pc; stk_ok[sp] = 1'b1; sp = sp + 4'd1; pc = op[11:0];
         end
         GRP_SE: if (a == kk) pc = pc + 12'd2;
         GRP_SNE: if (a != kk) pc = pc + 12'd2;
         GRP_SER: if (a == b) pc = pc + 12'd2;
         GRP_SNER: if (a != b) pc = pc + 12'd2;
         GRP_LD: vreg[x] = kk;
         GRP_ADD: vreg[x] = a + kk;
         GRP_ALU: begin
            case (n)
               ALU_MOV: vreg[x] = b;
               ALU_OR: vreg[x] = a | b;
               ALU_AND: vreg[x] = a & b;
               ALU_XOR: vreg[x] = a ^ b;
               ALU_ADD: begin
                  sum = {1'b0, a} + {1'b0, b}; vreg[x] = sum[7:0]; vreg[VF] = {7'd0, sum[8]};
               end
               ALU_SUB: begin vreg[x] = a - b; vreg[VF] = {7'd0, a >= b}; end
               ALU_SHR: begin vreg[x] = a >> 1; vreg[VF] = {7'd0, a[0]}; end
               ALU_SUBN: begin vreg[x] = b - a; vreg[VF] = {7'd0, b >= a}; end
               ALU_SHL: begin vreg[x] = a << 1; vreg[VF] = {7'd0, a[7]}; end
               default: r.unsup = 1'b1;
            endcase
         end
         GRP_LDI: ireg = op[11:0];
         GRP_JPV: pc = op[11:0] + {4'd0, vreg[0]};
         GRP_DRW: begin
            col = a[5:0]; row = b[4:0]; hit = 1'b0;
            for (int i = 0; i < n; i++) begin
               if (row + i < c8ic_pkg::SCREEN_HEIGHT) begin
                  addr = ireg + i[11:0];
                  bits = {mem[addr], 56'd0} >> col;
                  if ((disp[row + i] & bits) != 0) hit = 1'b1;
                  disp[row + i] ^= bits;
               end
            end
            vreg[VF] = {7'd0, hit};
            r.changed = 1'b1;
         end
         GRP_MISC: begin
            if (kk == FX_GETDT) vreg[x] = dtimer;
            else if (kk == FX_SETDT) dtimer = a;
            else if (kk == FX_SETST) stimer = a;
            else if (kk == FX_ADDI) ireg = ireg + {4'd0, a};
            else r.unsup = 1'b1;
         end
         default: r.unsup = 1'b1;
      endcase
   endfunction

   function automatic core_result_t predict_item(logic [31:0] word);
      core_result_t r;
      r = '0;
      case (word[1:0])
         c8ic_pkg::ACT_LOAD: begin
            mem[word[13:2]] = word[21:14]; mem_ok[word[13:2]] = 1'b1;
         end
         c8ic_pkg::ACT_READ: r.pixels = disp[word[26:22]];
         c8ic_pkg::ACT_STEP: execute_step(r);
         default: ;
      endcase
      r.pc = pc;
      return r;
   endfunction

   // opcode at pc may run without reading unwritten storage
   function automatic logic op_is_safe(logic [15:0] op);
      int row;
      if (op == OP_RET) return stk_ok[sp - 4'd1];
      if (op[15:12] == GRP_DRW) begin
         row = vreg[op[7:4]][4:0];
         for (int i = 0; i < op[3:0]; i++)
            if (row + i < c8ic_pkg::SCREEN_HEIGHT && !mem_ok[ireg + i[11:0]]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic fetch_is_safe();
      if (!mem_ok[pc] || !mem_ok[pc + 12'd1]) return 1'b0;
      return op_is_safe({mem[pc], mem[pc + 12'd1]});
   endfunction

   task automatic send_item(logic [1:0] act, logic [11:0] addr, logic [7:0] data,
                            logic [4:0] row);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, row, data, addr, act};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_item({5'd0, row, data, addr, act}));
      items_sent++;
   endtask

   task automatic load_byte(logic [11:0] addr, logic [7:0] data);
      send_item(c8ic_pkg::ACT_LOAD, addr, data, 5'($urandom));
   endtask

   task automatic step_once();
      send_item(c8ic_pkg::ACT_STEP, 12'($urandom), 8'($urandom), 5'($urandom));
   endtask

   // place the opcode at pc, with sprite bytes where needed, then execute it
   task automatic run_op(logic [15:0] op);
      int row;
      if (op == OP_RET && !stk_ok[sp - 4'd1]) op = {GRP_LD, op[11:0]};
      if (op[15:12] == GRP_DRW) begin
         row = vreg[op[7:4]][4:0];
         for (int i = 0; i < op[3:0]; i++)
            if (row + i < c8ic_pkg::SCREEN_HEIGHT && !mem_ok[ireg + i[11:0]])
               load_byte(ireg + i[11:0], 8'($urandom));
      end
      load_byte(pc, op[15:8]);
      load_byte(pc + 12'd1, op[7:0]);
      step_once();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start(logic [11:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      pc = value;
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_op();
      logic [15:0] op;
      logic [7:0]  fx [5];
      fx = '{FX_GETDT, FX_SETDT, FX_SETST, FX_ADDI, 8'($urandom)};
      op = 16'($urandom);
      case (op[15:12])
         GRP_SYS: case ($urandom_range(3))
            0: op = OP_CLS;
            1, 2: op = OP_RET;
            default: ;
         endcase
         GRP_ALU: if ($urandom_range(3) != 0)
            op[3:0] = 4'($urandom_range(7)) | ($urandom_range(4) == 0 ? ALU_SHL : 4'h0);
         GRP_DRW: if ($urandom_range(5) != 0) op[3:0] = 4'($urandom_range(5));
         GRP_MISC: op[7:0] = fx[$urandom_range(4)];
         default: ;
      endcase
      return op;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      core_result_t want, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.pc = rsp_tdata[11:0];
            got.opcode = rsp_tdata[27:12];
            got.changed = rsp_tdata[28];
            got.unsup = rsp_tdata[29];
            got.pixels = rsp_tdata[93:30];
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata[63:0], '0);
            end else begin
               want = pending_results.pop_front();
               if (got.pc != want.pc) report_mismatch("pc_value", got.pc, want.pc);
               if (got.opcode != want.opcode)
                  report_mismatch("opcode_seen", got.opcode, want.opcode);
               if (got.changed != want.changed)
                  report_mismatch("screen_changed", got.changed, want.changed);
               if (got.unsup != want.unsup)
                  report_mismatch("unsupported", got.unsup, want.unsup);
               if (got.pixels != want.pixels)
                  report_mismatch("row_pixels", got.pixels, want.pixels);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_actions();
      load_byte(12'h000, 8'h00);
      load_byte(12'hFFF, 8'hFF);
      send_item(ACT_NONE, 12'hFFF, 8'hFF, 5'd31);
      send_item(c8ic_pkg::ACT_READ, 12'h000, 8'h00, 5'd0);
      send_item(c8ic_pkg::ACT_READ, 12'hFFF, 8'hFF, 5'd31);
   endtask

   task automatic test_alu();
      logic [3:0] ops [10];
      ops = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN,
              ALU_SHL, ALU_BAD};
      foreach (ops[i]) begin
         run_op({GRP_LD, 4'h1, 8'hFF});
         run_op({GRP_LD, 4'h2, 8'h81});
         run_op({GRP_ALU, 4'h1, 4'h2, ops[i]});
         run_op({GRP_LD, VF, 8'h01});
         run_op({GRP_ALU, VF, 4'h1, ops[i]});
      end
   endtask

   task automatic test_flow();
      run_op(OP_CLS);
      run_op({GRP_CALL, 12'h600});
      run_op({GRP_CALL, 12'hA00});
      run_op(OP_RET);
      run_op(OP_RET);
      run_op({GRP_SYS, 12'h123});
      run_op({GRP_JP, 12'h400});
      run_op({GRP_LD, 4'h3, 8'h42});
      run_op({GRP_SE, 4'h3, 8'h42});
      run_op({GRP_SNE, 4'h3, 8'h42});
      run_op({GRP_SER, 4'h3, 4'h3, 4'h0});
      run_op({GRP_SNER, 4'h3, 4'h1, 4'h0});
      run_op({GRP_LD, 4'h0, 8'hFF});
      run_op({GRP_JPV, 12'hFF0});
      run_op({GRP_MISC, 4'h3, FX_SETDT});
      run_op({GRP_MISC, 4'h3, FX_SETST});
      run_op({GRP_MISC, 4'h4, FX_GETDT});
      run_op({GRP_LDI, 12'hFFE});
      run_op({GRP_MISC, 4'h3, FX_ADDI});
      run_op({GRP_MISC, 4'h3, FX_BCD});
      run_op({GRP_KEY, 4'h1, 8'h9E});
      run_op({GRP_RND, 4'h1, 8'hFF});
   endtask

   task automatic test_draw();
      run_op({GRP_LD, 4'h0, 8'd60});
      run_op({GRP_LD, 4'h1, 8'd30});
      run_op({GRP_LDI, 12'hFFC});
      run_op({GRP_DRW, 4'h0, 4'h1, 4'hF});
      run_op({GRP_DRW, 4'h0, 4'h1, 4'hF});
      run_op({GRP_LD, 4'h0, 8'hFF});
      run_op({GRP_LD, 4'h1, 8'hFF});
      run_op({GRP_DRW, 4'h0, 4'h1, 4'h2});
      run_op({GRP_DRW, 4'h0, 4'h1, 4'h0});
      send_item(c8ic_pkg::ACT_READ, 12'h000, 8'h00, 5'd30);
      send_item(c8ic_pkg::ACT_READ, 12'h000, 8'h00, 5'd31);
   endtask

   task automatic test_start_wrap();
      write_start(12'hFFF);
      run_op({GRP_LD, 4'h5, 8'h5A});
      write_start(12'h000);
      run_op({GRP_JP, 12'hFFE});
      run_op({GRP_ADD, 4'h5, 8'hFF});
   endtask

   task automatic test_random(int count, int tx_pct, int rx_pct);
      int target;
      int pick;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 6) load_byte(12'($urandom), 8'($urandom));
         else if (pick < 12)
            send_item(c8ic_pkg::ACT_READ, 12'($urandom), 8'($urandom), 5'($urandom));
         else if (pick < 14) send_item(ACT_NONE, 12'($urandom), 8'($urandom), 5'($urandom));
         else if (pick < 40 && fetch_is_safe()) step_once();
         else run_op(random_op());
      end
   endtask

   initial begin
      for (int i = 0; i < c8ic_pkg::MEM_BYTES; i++) begin
         mem[i] = '0; mem_ok[i] = 1'b0;
      end
      for (int i = 0; i < c8ic_pkg::SCREEN_HEIGHT; i++) disp[i] = '0;
      for (int i = 0; i < 16; i++) vreg[i] = '0;
      for (int i = 0; i < c8ic_pkg::STACK_DEPTH; i++) begin
         stk[i] = '0; stk_ok[i] = 1'b0;
      end
      pc = c8ic_pkg::START_RESET; ireg = '0; sp = '0; dtimer = '0; stimer = '0;
      tx_idle_pct = 31;
      rx_idle_pct = 83;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_actions();
      test_alu();
      test_flow();
      test_draw();
      test_start_wrap();
      test_random(500, 31, 83);
      write_start(12'(($urandom_range(4094))));
      test_random(500, 83, 31);
      write_start(12'hFFF);
      test_random(400, 0, 0);
      drain();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
